// ===== rtl/core/trb_pkg.sv =====
// Types, class codes and serial-order helper for the TCP reorder buffer.
// Used by trb_cell and tcp_segment_reorder_buffer_top.
package trb_pkg;

  localparam logic [2:0] CLS_IGNORE = 3'd0;
  localparam logic [2:0] CLS_SYN    = 3'd1;
  localparam logic [2:0] CLS_ACK    = 3'd2;
  localparam logic [2:0] CLS_RETX   = 3'd3;
  localparam logic [2:0] CLS_FIN    = 3'd4;
  localparam logic [2:0] CLS_RST    = 3'd5;
  localparam logic [2:0] CLS_DATA   = 3'd6;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic [2:0]  cls;
    logic [15:0] handle;
    logic [63:0] stamp;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic sorted;
  } cell_ctrl_t;

  function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// ===== rtl/core/trb_cell.sv =====
// One slot of the sorted segment chain: holds an entry and a valid bit.
// Depends on trb_pkg; shifts toward either neighbor on insert or pop.
module trb_cell import trb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  logic       left_valid,
  input  logic       left_at,
  input  entry_t     right_entry,
  input  logic       right_valid,
  input  logic       prefix_in,
  output logic       prefix_out,
  output logic       at,
  output logic       last_gt,
  output entry_t     entry,
  output logic       valid
);

  logic gt;

  assign gt         = valid && seq_after(entry.seq, new_entry.seq);
  assign prefix_out = prefix_in || gt;
  assign at         = ctrl.sorted ? prefix_out : !valid;
  assign last_gt    = valid && !right_valid && gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= right_valid;
    end else if (ctrl.push && at) begin
      valid <= left_at ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      entry <= right_entry;
    end else if (ctrl.push && at) begin
      entry <= left_at ? left_entry : new_entry;
    end
  end

endmodule

// ===== rtl/core/tcp_segment_reorder_buffer_top.sv =====
// Top level of the TCP segment reorder buffer: classifier, pop logic and
// a chain of trb_cell slots. Depends on trb_pkg and trb_cell.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per item:
//   kind 0 pushes a segment, kind 1 pops the next in-order segment.
//   Output channel (out_valid/out_stall) returns exactly one result per
//   item, in order, from an output register.
//   The result appears in the cycle after its input is accepted.
//   Throughput: one item per cycle unless the receiver stalls; the chain
//   of slots inserts or shifts at once, the insert position rippling through cells.
//   When the receiver stalls, the held result stays put and in_stall is
//   raised until it is taken, so at most one result is in flight.
//   Reset (rst, synchronous) empties the chain and clears the expected
//   number; slot contents are not cleared, only their valid bits.
//   A push into a full chain is classified and reported with overflow
//   set; a pop with an empty or gapped chain returns pop_valid 0.
module tcp_segment_reorder_buffer_top import trb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic        keep,
  input  logic [31:0] tcp_sequence,
  input  logic [15:0] ip_total_length,
  input  logic [3:0]  ip_header_words,
  input  logic [3:0]  tcp_header_words,
  input  logic        flag_syn,
  input  logic        flag_ack,
  input  logic        flag_fin,
  input  logic        flag_rst,
  input  logic [15:0] record_handle,
  input  logic [63:0] timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  push_class,
  output logic        overflow,
  output logic        pop_valid,
  output logic [31:0] pop_sequence,
  output logic [15:0] pop_length,
  output logic [2:0]  pop_class,
  output logic [15:0] pop_handle,
  output logic [63:0] pop_timestamp,
  output logic [6:0]  occupancy,
  output logic [31:0] next_expected
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [31:0]   expected;
  logic [31:0]   expected_next;

  logic          accept;
  logic          full;
  logic          do_push;
  logic          do_pop;
  logic [17:0]   plen;
  logic [15:0]   len;
  logic [2:0]    cls;
  logic [31:0]   pop_end;
  logic          any_last_gt;
  cell_ctrl_t    ctrl;
  entry_t        new_entry;

  entry_t              cell_entry [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_at;
  logic [DEPTH-1:0]    cell_last_gt;
  logic [DEPTH:0]      prefix;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count >= CW'(DEPTH));

  assign plen = {2'b00, ip_total_length} - {12'd0, ip_header_words, 2'b00}
              - {12'd0, tcp_header_words, 2'b00};
  assign len  = plen[17] ? 16'd0 : plen[15:0];

  always_comb begin
    if (flag_syn) begin
      cls = CLS_SYN;
    end else if (flag_ack && !flag_fin && len == 16'd0) begin
      cls = CLS_ACK;
    end else if (seq_after(expected, tcp_sequence)) begin
      cls = CLS_RETX;
    end else if (flag_fin) begin
      cls = CLS_FIN;
    end else if (flag_rst) begin
      cls = CLS_RST;
    end else begin
      cls = CLS_DATA;
    end
  end

  assign new_entry = '{seq: tcp_sequence, len: len, cls: cls,
                       handle: record_handle, stamp: timestamp};

  assign do_push = accept && !kind && keep && !full;
  assign do_pop  = accept && kind && cell_valid[0]
                && !seq_after(cell_entry[0].seq, expected);

  assign any_last_gt = |cell_last_gt;
  assign ctrl = '{push: do_push, pop: do_pop, sorted: any_last_gt};
  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_v;
    logic   left_a;
    entry_t right_e;
    logic   right_v;
    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_v = 1'b0;
      assign left_a = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_v = cell_valid[i-1];
      assign left_a = cell_at[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = new_entry;
      assign right_v = 1'b0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
      assign right_v = cell_valid[i+1];
    end
    trb_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .left_at     (left_a),
      .right_entry (right_e),
      .right_valid (right_v),
      .prefix_in   (prefix[i]),
      .prefix_out  (prefix[i+1]),
      .at          (cell_at[i]),
      .last_gt     (cell_last_gt[i]),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i])
    );
  end

  assign pop_end = cell_entry[0].seq + {16'd0, cell_entry[0].len};

  always_comb begin
    expected_next = expected;
    count_next    = count;
    if (accept && !kind && keep && flag_syn) begin
      expected_next = tcp_sequence;
    end
    if (do_push) begin
      count_next = count + CW'(1);
    end
    if (do_pop) begin
      count_next = count - CW'(1);
      case (cell_entry[0].cls)
        CLS_SYN, CLS_FIN: expected_next = expected + 32'd1;
        CLS_DATA:         expected_next = pop_end;
        CLS_RETX: begin
          if (seq_after(pop_end, expected)) begin
            expected_next = pop_end;
          end
        end
        default: expected_next = expected;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      expected  <= '0;
      out_valid <= 1'b0;
    end else begin
      count    <= count_next;
      expected <= expected_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_class    <= (!kind && keep) ? cls : CLS_IGNORE;
      overflow      <= !kind && keep && full;
      pop_valid     <= do_pop;
      pop_sequence  <= do_pop ? cell_entry[0].seq : 32'd0;
      pop_length    <= do_pop ? cell_entry[0].len : 16'd0;
      pop_class     <= do_pop ? cell_entry[0].cls : CLS_IGNORE;
      pop_handle    <= do_pop ? cell_entry[0].handle : 16'd0;
      pop_timestamp <= do_pop ? cell_entry[0].stamp : 64'd0;
      occupancy     <= 7'(count_next);
      next_expected <= expected_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_overflow_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> push_class != CLS_IGNORE && !pop_valid)
    else $error("overflow without a kept push");

  a_pop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop_valid |-> pop_class == CLS_IGNORE && pop_sequence == 32'd0)
    else $error("pop fields not cleared");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    do_push |=> count == $past(count) + CW'(1))
    else $error("push did not advance count");
`endif

endmodule
